// ===== rtl/core/itp_pkg.sv =====
// itp_pkg: shared types, character codes and helper functions for the
// integer text parser. No dependencies.
package itp_pkg;

  localparam int unsigned ValueWidth = 64;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_SIGN   = 4'b0001,
    PH_PREFIX = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  // Base codes, shared by the base_mode register and the active base.
  typedef enum logic [1:0] {
    BASE_AUTO = 2'd0,
    BASE_DEC  = 2'd1,
    BASE_OCT  = 2'd2,
    BASE_HEX  = 2'd3
  } base_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_NONE  = 8'h00;

  localparam logic [4:0] NOT_DIGIT = 5'd31;
  localparam logic [4:0] RADIX_OCT = 5'd8;
  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [4:0] RADIX_HEX = 5'd16;

  // Per-number parse state.
  typedef struct packed {
    phase_t                  phase;
    logic                    neg;
    base_t                   base;
    logic [ValueWidth-1:0]   acc;
    logic                    seen;
  } itp_state_t;

  // One result request.
  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic                  matched;
    logic [7:0]            stop_char;
    logic                  at_end;
  } itp_result_t;

  localparam itp_state_t STATE_CLEAR = '{
    phase: PH_SIGN, neg: 1'b0, base: BASE_AUTO, acc: '0, seen: 1'b0
  };

  // Digit value of a character in any base, NOT_DIGIT otherwise.
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      d = c - CH_LC_A + 8'd10;
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      d = c - CH_UC_A + 8'd10;
    end else begin
      d = {3'b000, NOT_DIGIT};
    end
    return d[4:0];
  endfunction

  function automatic logic [4:0] radix_of(input base_t b);
    logic [4:0] r;
    case (b)
      BASE_OCT: r = RADIX_OCT;
      BASE_HEX: r = RADIX_HEX;
      default:  r = RADIX_DEC;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/itp_step.sv =====
// itp_step: next-state and result logic for one character of the parser.
// Depends on itp_pkg.
module itp_step (
  input  itp_pkg::itp_state_t  cur,
  input  itp_pkg::base_t       base_mode,
  input  logic [7:0]           char_in,
  input  logic                 end_of_stream,
  output itp_pkg::itp_state_t  nxt,
  output logic                 emit,
  output itp_pkg::itp_result_t result
);

  itp_pkg::itp_state_t   work;
  logic                  sign_taken;
  logic                  do_digit;
  logic [4:0]            digit;
  logic [4:0]            radix;
  logic [itp_pkg::ValueWidth-1:0] acc_shift;
  logic [itp_pkg::ValueWidth-1:0] acc_next;

  assign digit = itp_pkg::digit_value(char_in);

  // acc * radix + digit as shifts and adds: one add for octal and hex, two for decimal
  always_comb begin
    case (work.base)
      itp_pkg::BASE_OCT: acc_shift = {work.acc[60:0], 3'b000};
      itp_pkg::BASE_HEX: acc_shift = {work.acc[59:0], 4'b0000};
      default:           acc_shift = {work.acc[60:0], 3'b000} + {work.acc[62:0], 1'b0};
    endcase
    acc_next = acc_shift + {{(itp_pkg::ValueWidth-5){1'b0}}, digit};
  end

  always_comb begin
    work       = cur;
    sign_taken = 1'b0;
    do_digit   = 1'b0;
    if (cur.phase == itp_pkg::PH_SIGN) begin
      work.base  = base_mode;
      work.phase = (base_mode == itp_pkg::BASE_AUTO) ? itp_pkg::PH_PREFIX
                                                     : itp_pkg::PH_DIGITS;
      if (char_in == itp_pkg::CH_PLUS) begin
        work.neg   = 1'b0;
        sign_taken = 1'b1;
      end else if (char_in == itp_pkg::CH_MINUS) begin
        work.neg   = 1'b1;
        sign_taken = 1'b1;
      end
    end
    if (!sign_taken) begin
      case (work.phase)
        itp_pkg::PH_PREFIX: begin
          if (char_in == itp_pkg::CH_ZERO) begin
            work.seen  = 1'b1;
            work.acc   = '0;
            work.phase = itp_pkg::PH_ZERO;
          end else begin
            work.base = itp_pkg::BASE_DEC;
            do_digit  = 1'b1;
          end
        end
        itp_pkg::PH_ZERO: begin
          if (char_in == itp_pkg::CH_LC_X || char_in == itp_pkg::CH_UC_X) begin
            work.base  = itp_pkg::BASE_HEX;
            work.phase = itp_pkg::PH_DIGITS;
          end else begin
            work.base = itp_pkg::BASE_OCT;
            do_digit  = 1'b1;
          end
        end
        default: do_digit = 1'b1;
      endcase
    end
  end

  assign radix = itp_pkg::radix_of(work.base);

  always_comb begin
    nxt              = work;
    emit             = 1'b0;
    result.value     = cur.neg ? ('0 - cur.acc) : cur.acc;
    result.matched   = cur.seen;
    result.stop_char = char_in;
    result.at_end    = 1'b0;
    if (end_of_stream) begin
      nxt              = itp_pkg::STATE_CLEAR;
      emit             = 1'b1;
      result.stop_char = itp_pkg::CH_NONE;
      result.at_end    = 1'b1;
    end else if (do_digit) begin
      nxt.phase = itp_pkg::PH_DIGITS;
      if (digit >= radix) begin
        // value, sign and seen flag are unchanged by the prefix handling
        nxt  = itp_pkg::STATE_CLEAR;
        emit = 1'b1;
      end else begin
        nxt.acc  = acc_next;
        nxt.seen = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/integer_text_parser.sv =====
// integer_text_parser: top level; input register, parse state, result register.
// Depends on itp_pkg and itp_step.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | char_in, end_of_stream
//  out      | out_valid / out_stall| number_value, matched, stop_char,
//           |                      | stopped_at_end
//  cfg      | cfg_valid / cfg_ready| base_mode (always ready)
//
// One character request per cycle, sustained while no result is held. A
// character is registered in the input register, parsed against the number
// state and, if it ends a number, lands in the result register, which raises
// out_valid.
// The parse itself is at most two 64-bit adds (acc*8 + acc*2, then the digit).
// rst (synchronous) clears the number state, both valid flags, base_mode to
// decimal. A held result blocks parsing; in_stall then rises once the input
// register is full, combinationally from out_stall.
// base_mode is sampled on the first character of each number.
module integer_text_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] number_value,
  output logic        matched,
  output logic [7:0]  stop_char,
  output logic        stopped_at_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  base_mode
);

  itp_pkg::base_t       base_mode_reg;
  itp_pkg::itp_state_t  state;
  itp_pkg::itp_state_t  state_next;
  itp_pkg::itp_result_t result;
  logic                 emit;

  // input register
  logic       in_q_valid;
  logic [7:0] in_q_char;
  logic       in_q_eos;

  logic advance;  // result register can take a new request
  logic fire;     // the registered character is parsed this cycle
  logic in_take;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign fire      = in_q_valid && advance;
  assign in_stall  = in_q_valid && !advance;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode_reg <= itp_pkg::BASE_DEC;
    end else if (cfg_valid && cfg_ready) begin
      base_mode_reg <= itp_pkg::base_t'(base_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_char <= char_in;
      in_q_eos  <= end_of_stream;
    end
  end

  itp_step u_step (
    .cur           (state),
    .base_mode     (base_mode_reg),
    .char_in       (in_q_char),
    .end_of_stream (in_q_eos),
    .nxt           (state_next),
    .emit          (emit),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itp_pkg::STATE_CLEAR;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      number_value   <= result.value;
      matched        <= result.matched;
      stop_char      <= result.stop_char;
      stopped_at_end <= result.at_end;
    end
  end

  // a number ended by end of stream leaves a clean state
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && in_q_eos) |=> (state.phase == itp_pkg::PH_SIGN && state.acc == '0))
    else $error("state not cleared after end of stream");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (fire && emit) |=> out_valid)
    else $error("result request lost");

  a_unmatched_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !matched) |-> (number_value == '0))
    else $error("nonzero value without digits");

  a_end_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stopped_at_end) |-> (stop_char == itp_pkg::CH_NONE))
    else $error("stop character set on end of stream");

  a_acc_needs_digit: assert property (@(posedge clk) disable iff (rst)
    !state.seen |-> (state.acc == '0))
    else $error("accumulator moved without a digit");

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state.phase))
    else $error("phase not one-hot");

endmodule
